FILE: sv/softmax_argmax_sigmoid_head_defines.svh
// ----------------------------------------------------------------------------
// Classifier head assertion macros
// Shared concurrent assertion forms for the classifier head RTL.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_ARGMAX_SIGMOID_HEAD_DEFINES_SVH
`define SOFTMAX_ARGMAX_SIGMOID_HEAD_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SAH_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SAH_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sah_pkg.sv
// ----------------------------------------------------------------------------
// Classifier head package
// Fixed-point constants, the 2^(-k/16) table and shared helper functions.
// ----------------------------------------------------------------------------
package sah_pkg;

   // Default configuration
   localparam int NUM_CLASSES_DEFAULT = 5;
   localparam int LOGIT_WIDTH_DEFAULT = 16;

   // Gap handling: gaps above 16.0 (Q8.8) give a zero term
   localparam int GAP_W     = 13;
   localparam int GAP_LIMIT = 4096;

   // Exponential datapath widths
   localparam int LOG2E_W = 17;
   localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
   localparam int PROD_W  = GAP_W + LOG2E_W;
   localparam int U_W     = 29;
   localparam int N_W     = 5;
   localparam int K_W     = 4;
   localparam int R_W     = 16;
   localparam int U_N_LSB = 24;
   localparam int U_K_LSB = 20;
   localparam int U_R_LSB = 4;
   localparam int TIDX_W  = K_W + 1;
   localparam int TERM_W  = 17;
   localparam int DIFF_W  = 12;
   localparam int FRAC_W  = 16;
   localparam int COR_W   = DIFF_W;
   localparam int IPROD_W = DIFF_W + R_W;

   // Result widths and divider shape
   localparam int PROB_W      = 16;
   localparam int DIV_STEPS   = 17;
   localparam int DIVIDEND_W  = 33;
   localparam logic [DIVIDEND_W-1:0] DIV_NUM_ONE = 33'h1_0000_0000;
   localparam int ONE_Q16     = 65536;
   localparam int FLAG_DEN_W  = 18;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // One gap lane as carried through the queue
   typedef struct packed {
      logic             zero;
      logic [GAP_W-1:0] gap;
   } sah_gap_type;

   // Width of one queue entry: best index, detect, sign, gap lanes
   function automatic int entry_w(input int num_classes);
      return $clog2(num_classes) + 2 + (num_classes + 1) * $bits(sah_gap_type);
   endfunction

   // round(65536 * 2^(-k/16)) for k = 0..16
   function automatic logic [TERM_W-1:0] pow2_neg(input logic [TIDX_W-1:0] k);
      logic [TERM_W-1:0] v;
      case (k)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62758;
         5'd2:    v = 17'd60097;
         5'd3:    v = 17'd57549;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         5'd16:   v = 17'd32768;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Saturate a 17-bit quotient to Q0.16
   function automatic logic [PROB_W-1:0] sat16(input logic [DIV_STEPS-1:0] q);
      return q[DIV_STEPS-1] ? {PROB_W{1'b1}} : q[PROB_W-1:0];
   endfunction

endpackage

FILE: sv/sah_req_if.sv
// ----------------------------------------------------------------------------
// Classifier head request channel
// Valid/ready channel carrying the category logits and the detector logit.
// ----------------------------------------------------------------------------
interface sah_req_if #(
   parameter int NUM_CLASSES = 5,
   parameter int LOGIT_WIDTH = 16
) ();
   logic                                   valid;
   logic                                   ready;
   logic [NUM_CLASSES-1:0][LOGIT_WIDTH-1:0] logit;
   logic signed [LOGIT_WIDTH-1:0]          flag_logit;

   modport source (output valid, output logit, output flag_logit, input ready);
   modport sink   (input valid, input logit, input flag_logit, output ready);
endinterface

FILE: sv/sah_rsp_if.sv
// ----------------------------------------------------------------------------
// Classifier head response channel
// Valid/ready channel carrying the winning class and the detector result.
// ----------------------------------------------------------------------------
interface sah_rsp_if #(
   parameter int NUM_CLASSES = 5
) ();
   logic                           valid;
   logic                           ready;
   logic [$clog2(NUM_CLASSES)-1:0] best_class;
   logic [15:0]                    best_probability;
   logic                           flag_detected;
   logic [15:0]                    flag_confidence;

   modport source (output valid, output best_class, output best_probability,
                   output flag_detected, output flag_confidence, input ready);
   modport sink   (input valid, input best_class, input best_probability,
                   input flag_detected, input flag_confidence, output ready);
endinterface

FILE: sv/sah_front.sv
// ----------------------------------------------------------------------------
// Classifier head front end
// Accepts a transaction, picks the winning class and forms clamped gaps.
// ----------------------------------------------------------------------------
module sah_front #(
   parameter int NUM_CLASSES = sah_pkg::NUM_CLASSES_DEFAULT,
   parameter int LOGIT_WIDTH = sah_pkg::LOGIT_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   sah_req_if.sink                                     req_ch,
   output logic                                        push_valid,
   input  logic                                        push_ready,
   output logic [sah_pkg::entry_w(NUM_CLASSES)-1:0]    push_data
);
   import sah_pkg::*;

   localparam int IDX_W = $clog2(NUM_CLASSES);
   localparam int EXT_W = LOGIT_WIDTH + 1;
   localparam int CMP_W = (EXT_W > GAP_W + 1) ? EXT_W : GAP_W + 1;

   // Clamp a non-negative gap; anything beyond 16.0 becomes a zero term
   function automatic sah_gap_type mk_gap(input logic [EXT_W-1:0] d);
      logic [CMP_W-1:0] w;
      sah_gap_type      g;
      w      = CMP_W'(d);
      g.zero = w > CMP_W'(GAP_LIMIT);
      g.gap  = w[GAP_W-1:0];
      return g;
   endfunction

   logic                                   en1;
   logic                                   en2;
   logic                                   f1_valid_ff;
   logic [NUM_CLASSES-1:0][LOGIT_WIDTH-1:0] f1_logit_ff;
   logic [LOGIT_WIDTH-1:0]                 f1_flag_ff;
   logic [NUM_CLASSES-1:0]                 f1_win_in;
   logic [NUM_CLASSES-1:0]                 f1_win_ff;
   logic                                   f2_valid_ff;
   logic [IDX_W-1:0]                       f2_best_in;
   logic [IDX_W-1:0]                       f2_best_ff;
   logic                                   f2_det_in;
   logic                                   f2_det_ff;
   logic                                   f2_neg_in;
   logic                                   f2_neg_ff;
   sah_gap_type [NUM_CLASSES:0]            f2_gap_in;
   sah_gap_type [NUM_CLASSES:0]            f2_gap_ff;

   // Advance each stage when the one after it can take its contents
   assign en2          = !f2_valid_ff || push_ready;
   assign en1          = !f1_valid_ff || en2;
   assign req_ch.ready = en1;

   // Pick the winner: beat every lower index, match or beat every higher one
   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         f1_win_in[i] = 1'b1;
         for (int j = 0; j < NUM_CLASSES; j++) begin
            if (j < i) begin
               if ($signed(req_ch.logit[j]) >= $signed(req_ch.logit[i])) begin
                  f1_win_in[i] = 1'b0;
               end
            end else if (j > i) begin
               if ($signed(req_ch.logit[j]) > $signed(req_ch.logit[i])) begin
                  f1_win_in[i] = 1'b0;
               end
            end
         end
      end
   end

   // Select the maximum, form the gaps and the detector magnitude
   always_comb begin
      logic [LOGIT_WIDTH-1:0] top;
      logic [EXT_W-1:0]       xe;
      logic [EXT_W-1:0]       mag;
      top        = '0;
      f2_best_in = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (f1_win_ff[i]) begin
            top        = top | f1_logit_ff[i];
            f2_best_in = f2_best_in | IDX_W'(i);
         end
      end
      for (int i = 0; i < NUM_CLASSES; i++) begin
         f2_gap_in[i] = mk_gap({top[LOGIT_WIDTH-1], top} -
                               {f1_logit_ff[i][LOGIT_WIDTH-1], f1_logit_ff[i]});
      end
      xe  = {f1_flag_ff[LOGIT_WIDTH-1], f1_flag_ff};
      mag = f1_flag_ff[LOGIT_WIDTH-1] ? (EXT_W'(0) - xe) : xe;
      f2_gap_in[NUM_CLASSES] = mk_gap(mag);
      f2_neg_in = f1_flag_ff[LOGIT_WIDTH-1];
      f2_det_in = !f1_flag_ff[LOGIT_WIDTH-1] && (f1_flag_ff != '0);
   end

   // Hold stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         if (en1) f1_valid_ff <= req_ch.valid;
         if (en2) f2_valid_ff <= f1_valid_ff;
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (en1) begin
         f1_logit_ff <= req_ch.logit;
         f1_flag_ff  <= req_ch.flag_logit;
         f1_win_ff   <= f1_win_in;
      end
      if (en2) begin
         f2_best_ff <= f2_best_in;
         f2_det_ff  <= f2_det_in;
         f2_neg_ff  <= f2_neg_in;
         f2_gap_ff  <= f2_gap_in;
      end
   end

   assign push_valid = f2_valid_ff;
   assign push_data  = {f2_best_ff, f2_det_ff, f2_neg_ff, f2_gap_ff};

endmodule

FILE: sv/sah_queue.sv
// ----------------------------------------------------------------------------
// Classifier head decoupling queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`include "softmax_argmax_sigmoid_head_defines.svh"

module sah_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import sah_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Track occupancy
   always_comb begin
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop_fire)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   // Write the incoming transaction
   always_ff @(posedge clock) begin
      if (push_fire) slot_ff[wr_ptr_ff] <= push_data;
   end

   `SAH_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `SAH_ASSERT_NXT(a_count_up, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + CNT_W'(1), "queue count missed a push")

endmodule

FILE: sv/sah_div.sv
// ----------------------------------------------------------------------------
// Classifier head pipelined divider
// Restoring divider, one quotient bit per stage, 17-bit quotient.
// ----------------------------------------------------------------------------
module sah_div #(
   parameter int DEN_W = 18
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [sah_pkg::DIVIDEND_W-1:0] num,
   input  logic [DEN_W-1:0]               den,
   output logic [sah_pkg::DIV_STEPS-1:0]  quo
);
   import sah_pkg::*;

   localparam int CW = DEN_W + DIV_STEPS;

   logic [DIVIDEND_W-1:0] rem_ff [DIV_STEPS-1];
   logic [DEN_W-1:0]      den_ff [DIV_STEPS-1];
   logic [DIV_STEPS-1:0]  quo_ff [DIV_STEPS];

   // One quotient bit per stage, most significant first
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DIVIDEND_W-1:0] rem_src;
      logic [DEN_W-1:0]      den_src;
      logic [DIV_STEPS-1:0]  quo_src;
      logic [CW-1:0]         sub_w;
      logic                  ge_w;

      if (s == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      assign sub_w = CW'(den_src) << (DIV_STEPS - 1 - s);
      assign ge_w  = CW'(rem_src) >= sub_w;

      always_ff @(posedge clock) begin
         if (en) quo_ff[s] <= {quo_src[DIV_STEPS-2:0], ge_w};
      end

      if (s < DIV_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= ge_w ? DIVIDEND_W'(CW'(rem_src) - sub_w) : rem_src;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

FILE: sv/sah_back.sv
// ----------------------------------------------------------------------------
// Classifier head back end
// Exponential terms, registered sum tree, reciprocal and sigmoid dividers.
// ----------------------------------------------------------------------------
`include "softmax_argmax_sigmoid_head_defines.svh"

module sah_back #(
   parameter int NUM_CLASSES = sah_pkg::NUM_CLASSES_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     pop_valid,
   output logic                                     pop_ready,
   input  logic [sah_pkg::entry_w(NUM_CLASSES)-1:0] pop_data,
   sah_rsp_if.source                                rsp_ch
);
   import sah_pkg::*;

   localparam int IDX_W  = $clog2(NUM_CLASSES);
   localparam int LANES  = NUM_CLASSES + 1;
   localparam int LVLS   = $clog2(NUM_CLASSES);
   localparam int PAD    = 1 << LVLS;
   localparam int SUM_W  = TERM_W + LVLS;
   localparam int SIDE_W = IDX_W + 1;
   localparam int PRE    = 3 + LVLS;
   localparam int STAGES = PRE + DIV_STEPS;

   logic                 en;
   logic [IDX_W-1:0]     q_best;
   logic                 q_det;
   logic                 q_neg;
   sah_gap_type [NUM_CLASSES:0] q_gap;

   logic [STAGES-1:0]    vld_ff;
   logic [SIDE_W-1:0]    side_ff [STAGES];
   logic                 neg_ff [PRE];

   logic [PROD_W-1:0]    e1_prod_in [LANES];
   logic [U_W-1:0]       e1_u_ff    [LANES];
   logic                 e1_zero_ff [LANES];
   logic [TERM_W-1:0]    e2_hi_in   [LANES];
   logic [IPROD_W-1:0]   e2_prod_in [LANES];
   logic [TERM_W-1:0]    e2_hi_ff   [LANES];
   logic [COR_W-1:0]     e2_cor_ff  [LANES];
   logic [N_W-1:0]       e2_n_ff    [LANES];
   logic                 e2_zero_ff [LANES];
   logic [TERM_W-1:0]    e3_term_in [LANES];
   logic [TERM_W-1:0]    e3_term_ff [LANES];

   logic [SUM_W-1:0]     leaf [PAD];
   logic [SUM_W-1:0]     node_ff [PAD-1];
   logic [TERM_W-1:0]    fterm_ff [LVLS];

   logic [FLAG_DEN_W-1:0] flag_den;
   logic [DIVIDEND_W-1:0] flag_num;
   logic [DIV_STEPS-1:0]  cls_quo;
   logic [DIV_STEPS-1:0]  flag_quo;

   logic                 rsp_valid_ff;
   logic [IDX_W-1:0]     rsp_best_ff;
   logic [PROB_W-1:0]    rsp_prob_ff;
   logic                 rsp_det_ff;
   logic [PROB_W-1:0]    rsp_conf_ff;

   // Whole pipeline advances unless a finished result is held at the output
   assign en        = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = en;
   assign {q_best, q_det, q_neg, q_gap} = pop_data;

   // Hold stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], pop_valid};
      end
   end

   // Carry class index, detect and sign alongside the data
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= {q_best, q_det};
         neg_ff[0]  <= q_neg;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
         for (int s = 1; s < PRE; s++)    neg_ff[s]  <= neg_ff[s-1];
      end
   end

   // Exponential terms: scale by log2(e), interpolate the table, shift
   always_comb begin
      logic [TERM_W-1:0]  lo;
      logic [DIFF_W-1:0]  d;
      logic [TIDX_W-1:0]  k;
      logic [TERM_W-1:0]  p;
      for (int l = 0; l < LANES; l++) begin
         e1_prod_in[l] = q_gap[l].gap * LOG2E_Q16;
         k             = {1'b0, e1_u_ff[l][U_K_LSB +: K_W]};
         e2_hi_in[l]   = pow2_neg(k);
         lo            = pow2_neg(k + TIDX_W'(1));
         d             = DIFF_W'(e2_hi_in[l] - lo);
         e2_prod_in[l] = d * e1_u_ff[l][U_R_LSB +: R_W];
         p             = e2_hi_ff[l] - TERM_W'(e2_cor_ff[l]);
         e3_term_in[l] = e2_zero_ff[l] ? '0 : (p >> e2_n_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            e1_u_ff[l]    <= e1_prod_in[l][U_W-1:0];
            e1_zero_ff[l] <= q_gap[l].zero;
            e2_hi_ff[l]   <= e2_hi_in[l];
            e2_cor_ff[l]  <= e2_prod_in[l][IPROD_W-1:FRAC_W];
            e2_n_ff[l]    <= e1_u_ff[l][U_N_LSB +: N_W];
            e2_zero_ff[l] <= e1_zero_ff[l];
            e3_term_ff[l] <= e3_term_in[l];
         end
      end
   end

   // Leaves of the sum tree, padded with zeros
   for (genvar i = 0; i < PAD; i++) begin : g_leaf
      if (i < NUM_CLASSES) begin : g_term
         assign leaf[i] = SUM_W'(e3_term_ff[i]);
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // Registered pairwise sum tree, one level per cycle while the pipeline advances
   for (genvar k = 0; k < PAD - 1; k++) begin : g_node
      if (2 * k + 1 >= PAD - 1) begin : g_bottom
         always_ff @(posedge clock) begin
            if (en) node_ff[k] <= leaf[2*k+1-(PAD-1)] + leaf[2*k+2-(PAD-1)];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            if (en) node_ff[k] <= node_ff[2*k+1] + node_ff[2*k+2];
         end
      end
   end

   // Delay the detector term to line up with the tree root
   always_ff @(posedge clock) begin
      if (en) begin
         fterm_ff[0] <= e3_term_ff[NUM_CLASSES];
         for (int j = 1; j < LVLS; j++) fterm_ff[j] <= fterm_ff[j-1];
      end
   end

   // Sigmoid operands: 1/(1+e) for non-negative logits, e/(1+e) otherwise
   assign flag_den = FLAG_DEN_W'(ONE_Q16) + FLAG_DEN_W'(fterm_ff[LVLS-1]);
   assign flag_num = neg_ff[PRE-1] ? {fterm_ff[LVLS-1], {FRAC_W{1'b0}}} : DIV_NUM_ONE;

   sah_div #(.DEN_W(SUM_W)) u_cls_div (
      .clock (clock),
      .en    (en),
      .num   (DIV_NUM_ONE),
      .den   (node_ff[0]),
      .quo   (cls_quo)
   );

   sah_div #(.DEN_W(FLAG_DEN_W)) u_flag_div (
      .clock (clock),
      .en    (en),
      .num   (flag_num),
      .den   (flag_den),
      .quo   (flag_quo)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         {rsp_best_ff, rsp_det_ff} <= side_ff[STAGES-1];
         rsp_prob_ff <= sat16(cls_quo);
         rsp_conf_ff <= sat16(flag_quo);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.best_class       = rsp_best_ff;
   assign rsp_ch.best_probability = rsp_prob_ff;
   assign rsp_ch.flag_detected    = rsp_det_ff;
   assign rsp_ch.flag_confidence  = rsp_conf_ff;

   `SAH_ASSERT_IMP(a_prob_nonzero, clock, reset, rsp_valid_ff, rsp_prob_ff != '0, "winner probability is zero")
   `SAH_ASSERT_IMP(a_conf_detect, clock, reset, rsp_valid_ff && rsp_det_ff, rsp_conf_ff >= 16'h8000, "detected flag with confidence below one half")

endmodule

FILE: sv/softmax_argmax_sigmoid_head.sv
// Path: front registers f1 and f2, the queue, exponential registers e1 to e3,
//   ceil(log2(NUM_CLASSES)) sum levels, the divider stages and the output register.
// Throughput: one transaction per cycle unless stalled; the 17-stage restoring dividers and
//   the sum tree are fully pipelined, and a 4-entry queue decouples the two halves.
// Reset: synchronous, active high; clears valid bits, queue pointers and count.
// ----------------------------------------------------------------------------
// Classifier head top level
// Softmax winner with probability and sigmoid detector over a valid/ready stream.
// ----------------------------------------------------------------------------
module softmax_argmax_sigmoid_head #(
   parameter int NUM_CLASSES = sah_pkg::NUM_CLASSES_DEFAULT,
   parameter int LOGIT_WIDTH = sah_pkg::LOGIT_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sah_req_if.sink   req_ch,
   sah_rsp_if.source rsp_ch
);
   import sah_pkg::*;

   localparam int ENTRY_W = entry_w(NUM_CLASSES);

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // Classify: winner and gaps
   sah_front #(
      .NUM_CLASSES (NUM_CLASSES),
      .LOGIT_WIDTH (LOGIT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple front and back
   sah_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Compute terms, sum and quotients
   sah_back #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule
